// ===== src/kphr_pkg.sv =====
// Shared types and constants for the key press / hold / repeat unit.
package kphr_pkg;

	// Payload widths
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned STATE_W = 2;
	localparam int unsigned MASK_W  = 4;

	// Default width of the internal time arithmetic
	localparam int unsigned TIME_BITS_DEF = 32;

	// Configuration port
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes
	localparam logic [1:0] REG_PRESS_DELAY  = 2'd0;
	localparam logic [1:0] REG_REPEAT_DELAY = 2'd1;
	localparam logic [1:0] REG_EVENT_MASK   = 2'd2;

	// External state codes
	localparam logic [STATE_W-1:0] CODE_IDLE     = 2'd0;
	localparam logic [STATE_W-1:0] CODE_PRESSED  = 2'd1;
	localparam logic [STATE_W-1:0] CODE_HOLD     = 2'd2;
	localparam logic [STATE_W-1:0] CODE_RELEASED = 2'd3;

	// Key state, one-hot; bit position matches the event mask bit
	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_PRESSED  = 4'b0010,
		ST_HOLD     = 4'b0100,
		ST_RELEASED = 4'b1000
	} key_state_t;

	// Map the one-hot state to its external code
	function automatic logic [STATE_W-1:0] state_code(input key_state_t st);
		logic [STATE_W-1:0] code;
		unique case (st)
			ST_IDLE:     code = CODE_IDLE;
			ST_PRESSED:  code = CODE_PRESSED;
			ST_HOLD:     code = CODE_HOLD;
			ST_RELEASED: code = CODE_RELEASED;
			default:     code = CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== src/kphr_in_if.sv =====
// Sample channel: one key sample per item.
interface kphr_in_if
	import kphr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              key_down;
	logic [TICK_W-1:0] now_tick;
	logic [SLOT_W-1:0] key_slot;

	modport source (output valid, key_down, now_tick, key_slot, input ready);
	modport sink   (input valid, key_down, now_tick, key_slot, output ready);
endinterface

// ===== src/kphr_out_if.sv =====
// Result channel: one state/event item per sample.
interface kphr_out_if
	import kphr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               fire;
	logic [STATE_W-1:0] key_state;
	logic [SLOT_W-1:0]  event_slot;

	modport source (output valid, fire, key_state, event_slot, input ready);
	modport sink   (input valid, fire, key_state, event_slot, output ready);
endinterface

// ===== src/key_press_hold_repeat_fsm_unit.sv =====
// Key press / hold / repeat state machine with APB configuration port.
//
// Usage:
//   sample carries one key sample per item (key_down, now_tick, key_slot);
//   result returns exactly one item per sample: the new key state, whether
//   an event fired for it, and the sample's slot.
//   The APB port holds press_delay (0x0), repeat_delay (0x4) and
//   event_mask (0x8); write them only while no sample is in flight.
// Pipeline and throughput:
//   A sample is registered in stage 1 on acceptance; its result is registered
//   in stage 2 when stage 1 advances, and is offered from there.
//   One sample is taken every cycle while the result does not stall; the state
//   update of the second stage is the only loop.
// Reset:
//   arst_n clears the state to idle, both stored times and all
//   registers to zero, and empties both stages.
// Stall:
//   While result.ready is low the result holds, one more sample is taken
//   into the input register, then sample.ready drops until the result moves.
module key_press_hold_repeat_fsm_unit
	import kphr_pkg::*;
#(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	kphr_in_if.sink           sample,
	kphr_out_if.source        result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Configuration registers
	logic [DATA_W-1:0] press_delay_q;
	logic [DATA_W-1:0] repeat_delay_q;
	logic [MASK_W-1:0] event_mask_q;

	// Stage 1: registered sample
	logic              valid_s1;
	logic              key_down_s1;
	logic [TICK_W-1:0] now_tick_s1;
	logic [SLOT_W-1:0] key_slot_s1;

	// Key state
	key_state_t           state_q;
	logic [TIME_BITS-1:0] press_time_q;
	logic [TIME_BITS-1:0] repeat_time_q;

	// Stage 2: result register
	logic               valid_s2;
	logic               fire_s2;
	logic [STATE_W-1:0] key_state_s2;
	logic [SLOT_W-1:0]  event_slot_s2;

	// Next-state logic
	key_state_t           state_nxt;
	logic                 press_ok;
	logic                 press_take;
	logic                 rep_clear;
	logic                 rep_take;
	logic                 fire_nxt;
	logic                 advance_s1;
	logic [63:0]          now_w;
	logic [63:0]          pd_w;
	logic [63:0]          rd_w;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] pd_t;
	logic [TIME_BITS-1:0] rd_t;
	logic [TIME_BITS-1:0] press_elapsed;
	logic [TIME_BITS-1:0] rep_elapsed;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_delay_q  <= '0;
			repeat_delay_q <= '0;
			event_mask_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PRESS_DELAY:  press_delay_q  <= pwdata;
				REG_REPEAT_DELAY: repeat_delay_q <= pwdata;
				REG_EVENT_MASK:   event_mask_q   <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (paddr[3:2])
			REG_PRESS_DELAY:  prdata = press_delay_q;
			REG_REPEAT_DELAY: prdata = repeat_delay_q;
			REG_EVENT_MASK:   prdata = {{(DATA_W-MASK_W){1'b0}}, event_mask_q};
			default:          prdata = '0;
		endcase
	end

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance_s1   = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance_s1;

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			key_down_s1 <= sample.key_down;
			now_tick_s1 <= sample.now_tick;
			key_slot_s1 <= sample.key_slot;
		end
	end

	// Bring time and delays to the internal time width
	assign now_w = {{(64-TICK_W){1'b0}}, now_tick_s1};
	assign pd_w  = {{(64-DATA_W){1'b0}}, press_delay_q};
	assign rd_w  = {{(64-DATA_W){1'b0}}, repeat_delay_q};
	assign now_t = now_w[TIME_BITS-1:0];
	assign pd_t  = pd_w[TIME_BITS-1:0];
	assign rd_t  = rd_w[TIME_BITS-1:0];

	// Wrapping time differences
	assign press_elapsed = now_t - press_time_q;
	assign rep_elapsed   = now_t - repeat_time_q;
	assign press_ok      = (pd_t == '0) || (press_elapsed >= pd_t);

	// Advance the key state
	always_comb begin
		state_nxt  = state_q;
		press_take = 1'b0;
		rep_clear  = 1'b0;
		unique case (state_q)
			ST_IDLE, ST_RELEASED: begin
				if (key_down_s1) begin
					if (press_ok) begin
						state_nxt  = ST_PRESSED;
						press_take = (pd_t != '0);
					end
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_PRESSED, ST_HOLD: begin
				if (key_down_s1) begin
					state_nxt = ST_HOLD;
				end else begin
					state_nxt = ST_RELEASED;
					rep_clear = 1'b1;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Raise the event for the new state; hold repeats on the repeat timer
	always_comb begin
		fire_nxt = 1'b0;
		rep_take = 1'b0;
		if (|(event_mask_q & state_nxt)) begin
			if (state_nxt == ST_HOLD && rd_t != '0) begin
				rep_take = (rep_elapsed >= rd_t);
				fire_nxt = rep_take;
			end else begin
				fire_nxt = 1'b1;
			end
		end
	end

	// Update state and stored times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			press_time_q  <= '0;
			repeat_time_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
			if (press_take) begin
				press_time_q <= now_t;
			end
			if (rep_clear) begin
				repeat_time_q <= '0;
			end else if (rep_take) begin
				repeat_time_q <= now_t;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			fire_s2       <= fire_nxt;
			key_state_s2  <= state_code(state_nxt);
			event_slot_s2 <= key_slot_s1;
		end
	end

	assign result.valid      = valid_s2;
	assign result.fire       = fire_s2;
	assign result.key_state  = key_state_s2;
	assign result.event_slot = event_slot_s2;

	// A pending result shows the current key state
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (key_state_s2 == state_code(state_q)))
		else $error("result state differs from key state");

	// A fired event belongs to an enabled state
	a_fire_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && fire_s2) |-> (|(event_mask_q & state_q)))
		else $error("event fired for a masked state");

	// Repeat timer is only nonzero while holding
	a_repeat_only_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_HOLD) |-> (repeat_time_q == '0))
		else $error("repeat time set outside hold");

	// An accepted item lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> valid_s1)
		else $error("accepted item lost");

endmodule

// ===== dv/tb.sv =====
// Testbench for key_press_hold_repeat_fsm_unit: queued key samples, predicted key events, APB setup.
`timescale 1ns / 100ps

module tb;
	import kphr_pkg::*;

	localparam int unsigned HALF_PERIOD   = 1;
	localparam int unsigned RESET_CYCLES  = 4;
	localparam int unsigned IDLE_MAX      = 8;
	localparam int unsigned LONG_HOLD     = 64;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_SAMPLES = 80;
	localparam int unsigned PRINT_LIMIT   = 50;

	typedef struct packed {
		logic              down;
		logic [TICK_W-1:0] tick;
		logic [SLOT_W-1:0] slot;
	} key_sample_t;

	typedef struct packed {
		logic               fire;
		logic [STATE_W-1:0] key_state;
		logic [SLOT_W-1:0]  slot;
	} key_event_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	kphr_in_if  smp_if ();
	kphr_out_if res_if ();

	key_press_hold_repeat_fsm_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor copy of the registers and the key state
	logic [TICK_W-1:0]  cfg_press_delay;
	logic [TICK_W-1:0]  cfg_repeat_delay;
	logic [MASK_W-1:0]  cfg_event_mask;
	logic [STATE_W-1:0] key_state_q;
	logic [TICK_W-1:0]  last_press_tick;
	logic [TICK_W-1:0]  last_repeat_tick;

	key_sample_t sample_queue[$];
	key_event_t  key_events_due[$];

	int unsigned send_gap_max;
	int unsigned recv_stall_max;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned holds_requested;
	int unsigned holds_served;
	int unsigned quiet_cycles;
	int unsigned mismatch_count;
	int unsigned samples_taken;
	int unsigned results_seen;
	int unsigned fires_seen;
	int unsigned settings_used;
	int unsigned state_hits[4];
	logic [TICK_W-1:0] stroke_tick;

	always #(HALF_PERIOD) clk = ~clk;

	// Advance the predicted key state by one sample and return its event
	function automatic key_event_t next_key_event(input key_sample_t s);
		key_event_t        ev;
		logic [TICK_W-1:0] since;
		ev.fire = 1'b0;
		ev.slot = s.slot;
		if (s.down && (key_state_q == CODE_IDLE || key_state_q == CODE_RELEASED)) begin
			since = s.tick - last_press_tick;
			if (cfg_press_delay == '0) begin
				key_state_q = CODE_PRESSED;
			end else if (since >= cfg_press_delay) begin
				last_press_tick = s.tick;
				key_state_q = CODE_PRESSED;
			end
		end else if (s.down && key_state_q == CODE_PRESSED) begin
			key_state_q = CODE_HOLD;
		end else if (!s.down && (key_state_q == CODE_PRESSED || key_state_q == CODE_HOLD)) begin
			key_state_q = CODE_RELEASED;
			last_repeat_tick = '0;
		end else if (!s.down && key_state_q == CODE_RELEASED) begin
			key_state_q = CODE_IDLE;
		end
		// Raise the event; hold with a repeat delay fires only once the delay has passed
		if (cfg_event_mask[key_state_q]) begin
			if (key_state_q == CODE_HOLD && cfg_repeat_delay != '0) begin
				since = s.tick - last_repeat_tick;
				if (since >= cfg_repeat_delay) begin
					last_repeat_tick = s.tick;
					ev.fire = 1'b1;
				end
			end else begin
				ev.fire = 1'b1;
			end
		end
		ev.key_state = key_state_q;
		return ev;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("[%0t] MISMATCH %s", $time, what);
		end
	endtask

	// Compare one result item with the oldest predicted event
	task automatic check_key_event();
		key_event_t want;
		results_seen++;
		if (res_if.fire === 1'b1) fires_seen++;
		state_hits[res_if.key_state]++;
		if (key_events_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with no sample pending", results_seen));
			return;
		end
		want = key_events_due.pop_front();
		if (res_if.fire !== want.fire) begin
			report_mismatch($sformatf("result %0d fire %b, want %b",
				results_seen, res_if.fire, want.fire));
		end
		if (res_if.key_state !== want.key_state) begin
			report_mismatch($sformatf("result %0d key_state %0d, want %0d",
				results_seen, res_if.key_state, want.key_state));
		end
		if (res_if.event_slot !== want.slot) begin
			report_mismatch($sformatf("result %0d event_slot %0d, want %0d",
				results_seen, res_if.event_slot, want.slot));
		end
	endtask

	// Offer queued samples, waiting a drawn number of cycles before each one
	always @(posedge clk) begin : drv
		key_sample_t nxt;
		if (arst_n) begin
			if (smp_if.valid && smp_if.ready) begin
				key_events_due.insert(key_events_due.size(),
					next_key_event({smp_if.key_down, smp_if.now_tick, smp_if.key_slot}));
				samples_taken++;
			end
			if (!smp_if.valid || smp_if.ready) begin
				if (send_gap != 0) begin
					smp_if.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (sample_queue.size() != 0) begin
					nxt = sample_queue.pop_front();
					smp_if.valid    <= 1'b1;
					smp_if.key_down <= nxt.down;
					smp_if.now_tick <= nxt.tick;
					smp_if.key_slot <= nxt.slot;
					send_gap <= $urandom_range(send_gap_max, 0);
				end else begin
					smp_if.valid <= 1'b0;
				end
			end
		end
	end

	// Take results, stall a drawn number of cycles after each, hold off on request
	always @(posedge clk) begin : mon
		int unsigned stall;
		if (arst_n) begin
			stall = recv_stall;
			if (res_if.valid && res_if.ready) begin
				check_key_event();
				stall = $urandom_range(recv_stall_max, 0);
			end
			if (holds_served != holds_requested) begin
				holds_served <= holds_requested;
				stall = LONG_HOLD;
			end
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				recv_stall <= stall - 1;
			end else begin
				res_if.ready <= 1'b1;
				recv_stall <= 0;
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || psel || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("key_press_hold_repeat_fsm_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PRESS_DELAY:  cfg_press_delay = val;
			REG_REPEAT_DELAY: cfg_repeat_delay = val;
			REG_EVENT_MASK:   cfg_event_mask = val[MASK_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic [TICK_W-1:0] press_delay,
			input logic [TICK_W-1:0] repeat_delay, input logic [MASK_W-1:0] mask);
		apb_write(REG_PRESS_DELAY, press_delay);
		apb_write(REG_REPEAT_DELAY, repeat_delay);
		apb_write(REG_EVENT_MASK, DATA_W'(mask));
		settings_used++;
	endtask

	task automatic queue_sample(input logic down, input logic [TICK_W-1:0] tick,
			input logic [SLOT_W-1:0] slot);
		sample_queue.insert(sample_queue.size(), {down, tick, slot});
	endtask

	// Mostly whole keystrokes (press run then release run) with advancing time, some noise
	task automatic queue_typing(input int unsigned count, input int unsigned step_cap);
		int unsigned       held;
		int unsigned       lifted;
		int unsigned       k;
		logic [SLOT_W-1:0] slot;
		while (count != 0) begin
			if ($urandom_range(4, 0) == 0) begin
				queue_sample(1'($urandom_range(1, 0)), $urandom, SLOT_W'($urandom_range(15, 0)));
				count--;
			end else begin
				// now and then start just below the wrap point
				if ($urandom_range(9, 0) == 0) stroke_tick = 32'hFFFF_FFFF - $urandom_range(40, 0);
				slot = SLOT_W'($urandom_range(15, 0));
				held = $urandom_range(12, 1);
				lifted = $urandom_range(4, 1);
				for (k = 0; k < held + lifted && count != 0; k++) begin
					stroke_tick += $urandom_range(step_cap, 0);
					queue_sample(k < held, stroke_tick, slot);
					count--;
				end
			end
		end
	endtask

	// Wait until every sample is taken and every result is back
	task automatic wait_drain();
		do @(negedge clk);
		while (sample_queue.size() != 0 || smp_if.valid || key_events_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned phase;
		logic [TICK_W-1:0] pd;
		logic [TICK_W-1:0] rd;
		logic [MASK_W-1:0] mask;
		int unsigned cap;

		arst_n = 1'b0;
		smp_if.valid = 1'b0;
		smp_if.key_down = 1'b0;
		smp_if.now_tick = '0;
		smp_if.key_slot = '0;
		res_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_press_delay = '0;
		cfg_repeat_delay = '0;
		cfg_event_mask = '0;
		key_state_q = CODE_IDLE;
		last_press_tick = '0;
		last_repeat_tick = '0;
		send_gap_max = 0;
		recv_stall_max = 0;
		send_gap = 0;
		recv_stall = 0;
		holds_requested = 0;
		holds_served = 0;
		quiet_cycles = 0;
		mismatch_count = 0;
		samples_taken = 0;
		results_seen = 0;
		fires_seen = 0;
		settings_used = 0;
		state_hits = '{0, 0, 0, 0};
		stroke_tick = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk every transition with no delays and all events on
		set_config('0, '0, 4'hF);
		queue_sample(1'b0, 32'h0000_0000, 4'h0);
		queue_sample(1'b1, 32'h0000_0000, 4'hF);
		queue_sample(1'b1, 32'h0000_0001, 4'h3);
		queue_sample(1'b1, 32'h0000_0002, 4'h3);
		queue_sample(1'b0, 32'h0000_0003, 4'h3);
		queue_sample(1'b0, 32'h0000_0004, 4'h3);
		queue_sample(1'b1, 32'h0000_0005, 4'h5);
		queue_sample(1'b0, 32'h0000_0006, 4'h5);
		queue_sample(1'b1, 32'hFFFF_FFFF, 4'hA);
		queue_sample(1'b0, 32'h0000_0007, 4'hA);
		queue_sample(1'b0, 32'h0000_0008, 4'hA);
		wait_drain();

		// Press spacing, repeat spacing, repeat cleared on release, press across the wrap
		set_config(32'd100, 32'd10, 4'hF);
		queue_sample(1'b1, 32'd50, 4'h1);
		queue_sample(1'b1, 32'd100, 4'h1);
		queue_sample(1'b1, 32'd105, 4'h1);
		queue_sample(1'b1, 32'd110, 4'h1);
		queue_sample(1'b1, 32'd115, 4'h1);
		queue_sample(1'b0, 32'd116, 4'h1);
		queue_sample(1'b0, 32'd117, 4'h1);
		queue_sample(1'b1, 32'd150, 4'h2);
		queue_sample(1'b1, 32'hFFFF_FFF0, 4'h2);
		queue_sample(1'b0, 32'hFFFF_FFF8, 4'h2);
		queue_sample(1'b0, 32'h0000_0010, 4'h2);
		queue_sample(1'b1, 32'h0000_0050, 4'hE);
		queue_sample(1'b1, 32'h0000_0054, 4'hE);
		queue_sample(1'b1, 32'h0000_0060, 4'hE);
		wait_drain();

		// Random keystrokes under a series of register settings
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			cap = 15;
			case (phase)
				0: begin
					pd = '0;
					rd = '0;
					mask = 4'hF;
				end
				1: begin
					pd = 32'hFFFF_FFFF;
					rd = 32'hFFFF_FFFF;
					mask = 4'hF;
					cap = 1000;
				end
				2: begin
					pd = $urandom_range(40, 1);
					rd = $urandom_range(20, 1);
					mask = 4'hF;
				end
				3: begin
					pd = $urandom_range(60, 0);
					rd = $urandom_range(30, 0);
					mask = 4'h0;
				end
				default: begin
					pd = ($urandom_range(3, 0) == 0) ? '0 : TICK_W'($urandom_range(60, 1));
					rd = ($urandom_range(3, 0) == 0) ? '0 : TICK_W'($urandom_range(30, 1));
					mask = MASK_W'($urandom_range(15, 0));
				end
			endcase
			send_gap_max = (phase % 3 == 0) ? 0 : IDLE_MAX;
			recv_stall_max = (phase % 4 == 1) ? 0 : IDLE_MAX;
			set_config(pd, rd, mask);

			if (phase == 1) begin
				// with the widest press spacing, only one tick before the last press is far enough
				queue_sample(1'b0, stroke_tick, 4'h6);
				queue_sample(1'b0, stroke_tick, 4'h6);
				queue_sample(1'b1, last_press_tick - 1, 4'h9);
				queue_sample(1'b1, last_press_tick - 1, 4'h9);
			end
			if (phase == 2) begin
				// stop taking results for a long stretch while samples keep coming
				send_gap_max = 0;
				holds_requested++;
			end
			if (phase == 5) begin
				queue_typing(PHASE_SAMPLES / 2, cap);
				wait_drain();
				queue_typing(PHASE_SAMPLES / 2, cap);
			end else begin
				queue_typing(PHASE_SAMPLES, cap);
			end
			wait_drain();
		end

		if (key_events_due.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", key_events_due.size()));
		end
		$display("Covered %0d samples and %0d results (%0d with an event) over %0d register settings",
			samples_taken, results_seen, fires_seen, settings_used);
		$display("Results per state: idle %0d, pressed %0d, hold %0d, released %0d",
			state_hits[CODE_IDLE], state_hits[CODE_PRESSED], state_hits[CODE_HOLD],
			state_hits[CODE_RELEASED]);
		if (mismatch_count == 0) begin
			$display("key_press_hold_repeat_fsm_unit regression: pass");
		end else begin
			$display("key_press_hold_repeat_fsm_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/kphr_pkg.sv
src/kphr_in_if.sv
src/kphr_out_if.sv
src/key_press_hold_repeat_fsm_unit.sv
dv/tb.sv
